// ===== rtl/core/cor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants for the circle overlap resolver
// Word types, datapath command/status groups, fixed-point widths.
// ----------------------------------------------------------------------------
package cor_pkg;

  localparam int COORD_BITS      = 24;
  localparam int MAX_OBJECTS_DEF = 64;
  localparam int OUT_INDEX_W     = 6;

  // fixed-point widths
  localparam int SUM_W   = (COORD_BITS > 22) ? COORD_BITS + 2 : 24;
  localparam int MAG_W   = 22;               // |offset| below the far limit
  localparam int SPAN_W  = 21;
  localparam int ROOT_W  = 23;
  localparam int SQ_W    = 46;
  localparam int REM_W   = 26;
  localparam int PROD_W  = 44;
  localparam int DREM_W  = 24;
  localparam int Q_W     = 22;
  localparam int STEP_W  = 6;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = PROD_W;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPH_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPH_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPH_Z      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_z;
    logic                         in_last;
  } in_word_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0]       out_index;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         out_last;
  } out_word_t;

  typedef struct packed {
    logic load_in;     // write input word at addr
    logic rd_req;      // read store at addr
    logic cap_a;       // capture read data as object A
    logic cap_b;       // capture read data as object B
    logic cap_sph;     // load sphere center as B
    logic sph_mode;    // span = object + sphere radius
    logic diff;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic check;
    logic zero_dir;
    logic mul;
    logic div_init_x;
    logic div_init_z;  // also takes x quotient
    logic div_step;
    logic take_qz;
    logic wr_a;
    logic wr_b;
    logic out_load;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       d_zero;
    logic       out_busy;
    logic [3:0] pass_count;
  } dp_status_t;

endpackage

// ===== rtl/core/cor_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_datapath: store, config registers, sqrt/divide units, output register
// Executes one command word per cycle from the controller.
// ----------------------------------------------------------------------------
module cor_datapath
  import cor_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int IW          = $clog2(MAX_OBJECTS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  in_word_t               in_data,
  input  dp_cmd_t                cmd,
  input  logic [IW-1:0]          addr,
  input  logic [OUT_INDEX_W-1:0] out_index,
  output dp_status_t             status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_data
);

  localparam logic signed [SUM_W-1:0] SAT_HI    = SUM_W'((64'sd1 <<< (COORD_BITS-1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO    = -SUM_W'(64'sd1 <<< (COORD_BITS-1));
  localparam logic        [SUM_W-1:0] FAR_LIMIT = SUM_W'(64'd1 << MAG_W);

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[COORD_BITS-1:0];
    else if (v < SAT_LO) r = SAT_LO[COORD_BITS-1:0];
    else                 r = v[COORD_BITS-1:0];
    return r;
  endfunction

  // config
  logic [SPAN_W-2:0]            obj_r, sph_r;
  logic signed [COORD_BITS-1:0] sph_x, sph_z;
  logic [3:0]                   pass_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_r      <= 20'd6400;
      sph_r      <= 20'd25600;
      sph_x      <= '0;
      sph_z      <= '0;
      pass_count <= 4'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OBJ_RADIUS: obj_r      <= cfg_data[SPAN_W-2:0];
        CFG_SPH_RADIUS: sph_r      <= cfg_data[SPAN_W-2:0];
        CFG_SPH_X:      sph_x      <= cfg_data[COORD_BITS-1:0];
        CFG_SPH_Z:      sph_z      <= cfg_data[COORD_BITS-1:0];
        CFG_PASS_COUNT: pass_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // store
  logic signed [COORD_BITS-1:0] mem_x [MAX_OBJECTS];
  logic signed [COORD_BITS-1:0] mem_z [MAX_OBJECTS];
  logic signed [COORD_BITS-1:0] rd_x, rd_z, wr_x, wr_z;
  logic                         wr_en;

  // operands
  logic signed [COORD_BITS-1:0] xa, za, xb, zb;
  logic [MAG_W-1:0]             adx, adz;
  logic                         sx, sz, far;
  logic [2*MAG_W-1:0]           sqx, sqz;
  logic [SQ_W-1:0]              sq_s;
  logic [REM_W-1:0]             sq_rem;
  logic [ROOT_W-1:0]            root;
  logic                         hit, d_zero;
  logic [SPAN_W-1:0]            delta;
  logic [PROD_W-1:0]            px, pz, dnum;
  logic [DREM_W-1:0]            drem;
  logic [Q_W-1:0]               qx, qz;

  logic signed [SUM_W-1:0] mx, mz;
  assign mx = sx ? -SUM_W'(qx) : SUM_W'(qx);
  assign mz = sz ? -SUM_W'(qz) : SUM_W'(qz);

  always_comb begin
    wr_en = cmd.load_in | cmd.wr_a | cmd.wr_b;
    if (cmd.load_in) begin
      wr_x = in_data.in_x;
      wr_z = in_data.in_z;
    end else if (cmd.wr_a) begin
      wr_x = sat(SUM_W'(xa) + mx);
      wr_z = sat(SUM_W'(za) + mz);
    end else begin
      wr_x = sat(SUM_W'(xb) - mx);
      wr_z = sat(SUM_W'(zb) - mz);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[addr] <= wr_x;
      mem_z[addr] <= wr_z;
    end
    if (cmd.rd_req) begin
      rd_x <= mem_x[addr];
      rd_z <= mem_z[addr];
    end
  end

  // offset and magnitude
  logic signed [SUM_W-1:0] dx, dz;
  logic [SUM_W-1:0]        adx_f, adz_f;
  assign dx    = SUM_W'(xa) - SUM_W'(xb);
  assign dz    = SUM_W'(za) - SUM_W'(zb);
  assign adx_f = dx[SUM_W-1] ? -dx : dx;
  assign adz_f = dz[SUM_W-1] ? -dz : dz;

  // sqrt step
  logic [REM_W-1:0] rem_t, trial;
  assign rem_t = {sq_rem[REM_W-3:0], sq_s[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, root, 2'b01};

  // span check
  logic [SPAN_W-1:0] span;
  assign span = cmd.sph_mode ? ({1'b0, obj_r} + {1'b0, sph_r}) : {obj_r, 1'b0};

  // products
  logic [MAG_W+SPAN_W-1:0] prod_x, prod_z;
  assign prod_x = adx * delta;
  assign prod_z = adz * delta;

  // divide step, divisor 2d
  logic [DREM_W:0]   rem2;
  logic [DREM_W-1:0] dvs;
  assign dvs  = {root, 1'b0};
  assign rem2 = {drem, dnum[PROD_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      xa <= rd_x;
      za <= rd_z;
    end
    if (cmd.cap_b) begin
      xb <= rd_x;
      zb <= rd_z;
    end else if (cmd.cap_sph) begin
      xb <= sph_x;
      zb <= sph_z;
    end
    if (cmd.diff) begin
      sx  <= dx[SUM_W-1];
      sz  <= dz[SUM_W-1];
      far <= (adx_f >= FAR_LIMIT) || (adz_f >= FAR_LIMIT);
      adx <= adx_f[MAG_W-1:0];
      adz <= adz_f[MAG_W-1:0];
    end
    if (cmd.square) begin
      sqx <= adx * adx;
      sqz <= adz * adz;
    end
    if (cmd.sqrt_init) begin
      sq_s   <= SQ_W'(sqx) + SQ_W'(sqz);
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_s <= sq_s << 2;
      if (rem_t >= trial) begin
        sq_rem <= rem_t - trial;
        root   <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem <= rem_t;
        root   <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.check) begin
      hit    <= !far && ({2'b00, span} > root);
      d_zero <= (root == '0);
      delta  <= span - root[SPAN_W-1:0];
    end
    if (cmd.zero_dir) begin
      qx <= Q_W'(({1'b0, delta} + 1'b1) >> 1);
      qz <= '0;
    end
    if (cmd.mul) begin
      px <= PROD_W'(prod_x) + PROD_W'(root);
      pz <= PROD_W'(prod_z) + PROD_W'(root);
    end
    if (cmd.div_init_x || cmd.div_init_z) begin
      dnum <= cmd.div_init_x ? px : pz;
      drem <= '0;
      if (cmd.div_init_z) qx <= dnum[Q_W-1:0];
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, dvs}) begin
        drem <= DREM_W'(rem2 - {1'b0, dvs});
        dnum <= {dnum[PROD_W-2:0], 1'b1};
      end else begin
        drem <= rem2[DREM_W-1:0];
        dnum <= {dnum[PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.take_qz) qz <= dnum[Q_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.out_index <= out_index;
      out_data.out_x     <= rd_x;
      out_data.out_z     <= rd_z;
      out_data.out_last  <= cmd.out_last;
    end
  end

  assign status.hit        = hit;
  assign status.d_zero     = d_zero;
  assign status.out_busy   = out_valid;
  assign status.pass_count = pass_count;

endmodule

// ===== rtl/core/cor_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_ctrl: sequencer for load, pair passes, sphere pass and readout
// Owns object count, pair indices, pass counter and step counter.
// ----------------------------------------------------------------------------
module cor_ctrl
  import cor_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int IW          = $clog2(MAX_OBJECTS),
  parameter int CW          = $clog2(MAX_OBJECTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_last,
  input  dp_status_t             status,
  output dp_cmd_t                cmd,
  output logic [IW-1:0]          addr,
  output logic [OUT_INDEX_W-1:0] out_index
);

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_RDA   = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_CAPB  = 5'd4;
  localparam logic [4:0] S_SRD   = 5'd5;
  localparam logic [4:0] S_SCAP  = 5'd6;
  localparam logic [4:0] S_DIFF  = 5'd7;
  localparam logic [4:0] S_SQ    = 5'd8;
  localparam logic [4:0] S_SQI   = 5'd9;
  localparam logic [4:0] S_SQRT  = 5'd10;
  localparam logic [4:0] S_CHK   = 5'd11;
  localparam logic [4:0] S_BR    = 5'd12;
  localparam logic [4:0] S_ZERO  = 5'd13;
  localparam logic [4:0] S_MUL   = 5'd14;
  localparam logic [4:0] S_DIVIX = 5'd15;
  localparam logic [4:0] S_DIVX  = 5'd16;
  localparam logic [4:0] S_DIVIZ = 5'd17;
  localparam logic [4:0] S_DIVZ  = 5'd18;
  localparam logic [4:0] S_TAKEZ = 5'd19;
  localparam logic [4:0] S_WRA   = 5'd20;
  localparam logic [4:0] S_WRB   = 5'd21;
  localparam logic [4:0] S_NEXT  = 5'd22;
  localparam logic [4:0] S_EWAIT = 5'd23;
  localparam logic [4:0] S_ECAP  = 5'd24;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OBJECTS);

  logic [4:0]        state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [IW-1:0]     i, i_next, j, j_next;
  logic [3:0]        p, p_next;
  logic              sph, sph_next;
  logic [STEP_W-1:0] step, step_next;

  logic [CW-1:0] i_p1, i_p2, j_p1;
  assign i_p1 = CW'(i) + CW'(1);
  assign i_p2 = CW'(i) + CW'(2);
  assign j_p1 = CW'(j) + CW'(1);

  assign in_stall  = (state != S_LOAD);
  assign out_index = OUT_INDEX_W'(i);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    i_next     = i;
    j_next     = j;
    p_next     = p;
    sph_next   = sph;
    step_next  = step;
    cmd        = '0;
    cmd.sph_mode = sph;
    addr       = i;

    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt < MAX_CNT) begin
            cmd.load_in = 1'b1;
            addr        = cnt[IW-1:0];
            cnt_next    = cnt + CW'(1);
          end
          if (in_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        i_next = '0;
        j_next = IW'(1);
        p_next = '0;
        if (status.pass_count != 4'd0 && cnt >= CW'(2)) begin
          sph_next   = 1'b0;
          state_next = S_RDA;
        end else begin
          sph_next   = 1'b1;
          state_next = S_SRD;
        end
      end
      S_RDA: begin
        cmd.rd_req = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_req = 1'b1;
        addr       = j;
        state_next = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_b  = 1'b1;
        state_next = S_DIFF;
      end
      S_SRD: begin
        cmd.rd_req = 1'b1;
        state_next = S_SCAP;
      end
      S_SCAP: begin
        cmd.cap_a   = 1'b1;
        cmd.cap_sph = 1'b1;
        state_next  = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_SQI;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        step_next     = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + STEP_W'(1);
        if (step == STEP_W'(SQRT_STEPS - 1)) state_next = S_CHK;
      end
      S_CHK: begin
        cmd.check  = 1'b1;
        state_next = S_BR;
      end
      S_BR: begin
        if (!status.hit)        state_next = S_NEXT;
        else if (status.d_zero) state_next = S_ZERO;
        else                    state_next = S_MUL;
      end
      S_ZERO: begin
        cmd.zero_dir = 1'b1;
        state_next   = S_WRA;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVIX;
      end
      S_DIVIX: begin
        cmd.div_init_x = 1'b1;
        step_next      = '0;
        state_next     = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_DIVIZ;
      end
      S_DIVIZ: begin
        cmd.div_init_z = 1'b1;
        step_next      = '0;
        state_next     = S_DIVZ;
      end
      S_DIVZ: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_TAKEZ;
      end
      S_TAKEZ: begin
        cmd.take_qz = 1'b1;
        state_next  = S_WRA;
      end
      S_WRA: begin
        cmd.wr_a   = 1'b1;
        state_next = sph ? S_NEXT : S_WRB;
      end
      S_WRB: begin
        cmd.wr_b   = 1'b1;
        addr       = j;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (sph) begin
          if (i_p1 < cnt) begin
            i_next     = i + IW'(1);
            state_next = S_SRD;
          end else begin
            i_next     = '0;
            state_next = S_EWAIT;
          end
        end else if (j_p1 < cnt) begin
          j_next     = j + IW'(1);
          state_next = S_RDA;
        end else if (i_p2 < cnt) begin
          i_next     = i + IW'(1);
          j_next     = i_p2[IW-1:0];
          state_next = S_RDA;
        end else if ({1'b0, p} + 5'd1 < {1'b0, status.pass_count}) begin
          p_next     = p + 4'd1;
          i_next     = '0;
          j_next     = IW'(1);
          state_next = S_RDA;
        end else begin
          sph_next   = 1'b1;
          i_next     = '0;
          state_next = S_SRD;
        end
      end
      S_EWAIT: begin
        if (!status.out_busy) begin
          cmd.rd_req = 1'b1;
          state_next = S_ECAP;
        end
      end
      S_ECAP: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (i_p1 == cnt);
        if (i_p1 == cnt) begin
          cnt_next   = '0;
          state_next = S_LOAD;
        end else begin
          i_next     = i + IW'(1);
          state_next = S_EWAIT;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      i     <= '0;
      j     <= '0;
      p     <= '0;
      sph   <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      i     <= i_next;
      j     <= j_next;
      p     <= p_next;
      sph   <= sph_next;
      step  <= step_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAX_CNT)
    else $error("object count above store depth");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDB) |-> (j > i))
    else $error("pair read with j not above i");

  a_wrb_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRB) |-> !sph)
    else $error("second write during sphere pass");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVX || state == S_DIVZ) |-> (step < STEP_W'(DIV_STEPS)))
    else $error("divider step count overrun");

endmodule

// ===== rtl/core/circle_overlap_resolver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_resolver_core: iterative circle collision position fixer
// Loads (x, z) positions, relaxes overlapping pairs, pushes out of a sphere.
// ----------------------------------------------------------------------------
// Load takes one input word per cycle into a store of MAX_OBJECTS entries;
// words past the store depth are dropped, and the word with in_last starts
// resolution. During resolution the input is stalled. Each pair test is two
// store reads, squares, a 23-step bit-serial square root, check, branch and
// index update; a sphere test is the same with one store read.
// A pair that overlaps adds the multiply and two 44-step restoring divides,
// which set the bulk of the run time, plus two write-backs; a sphere hit
// adds the same with one write-back. Coincident objects skip the multiply
// and divides. One run is a start state, pass_count * n*(n-1)/2 pair tests,
// then n sphere tests, then readout of one output word at a time, each read
// waiting until the output register is empty. A new set may be loaded once
// the last word of the previous set has been handed to the output register.
// ----------------------------------------------------------------------------
module circle_overlap_resolver_core
  import cor_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  // output words
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  localparam int IW = $clog2(MAX_OBJECTS);
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  // controller/datapath link
  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [IW-1:0]          addr;
  logic [OUT_INDEX_W-1:0] out_index;

  // sequencer: load, pair passes, sphere pass, readout
  cor_ctrl #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_data.in_last),
    .status    (status),
    .cmd       (cmd),
    .addr      (addr),
    .out_index (out_index)
  );

  // store, arithmetic units, config and output register
  cor_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .IW          (IW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .addr      (addr),
    .out_index (out_index),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
